// ----- hdl/mppb_pkg.sv -----
package mppb_pkg;

   localparam int FRAME_WIDTH  = 160;
   localparam int FRAME_HEIGHT = 120;
   localparam int PALETTE_SIZE = 5;
   localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int POS_W        = $clog2(PIXEL_COUNT);
   localparam int PAL_REGS     = 5;

   localparam logic [21:0] PERIOD_RESET    = 22'd20000;
   localparam logic [7:0]  THRESHOLD_RESET = 8'd1;
   localparam logic [23:0] PAL0_RESET      = 24'h00E3DD;
   localparam logic [23:0] PAL1_RESET      = 24'h1537E8;
   localparam logic [23:0] PAL2_RESET      = 24'h5804B4;
   localparam logic [23:0] PAL3_RESET      = 24'hAA00AA;
   localparam logic [23:0] PAL4_RESET      = 24'hE6E6E6;

   localparam logic [2:0] REG_PERIOD    = 3'd0;
   localparam logic [2:0] REG_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_PAL0      = 3'd2;
   localparam logic [2:0] REG_PAL1      = 3'd3;
   localparam logic [2:0] REG_PAL2      = 3'd4;
   localparam logic [2:0] REG_PAL3      = 3'd5;
   localparam logic [2:0] REG_PAL4      = 3'd6;

   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_MIX,
      ST_PIX_READ,
      ST_PIX_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic div_start;
      logic mix_step;
      logic frame_update;
      logic pix_write;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic mode;
   } status_type;

endpackage

// ----- hdl/mppb_datapath.sv -----
module mppb_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mppb_pkg::cmd_type    cmd,
   output mppb_pkg::status_type status,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_data,
   input  logic                 in_mode,
   input  logic [31:0]          in_elapsed,
   input  logic [7:0]           in_pixel,
   output logic [23:0]          out_color,
   output logic                 out_frame_end
);

   localparam int PW = mppb_pkg::POS_W;

   logic [21:0] period_ff;
   logic [7:0]  threshold_ff;
   logic [23:0] pal_ff [mppb_pkg::PAL_REGS];

   logic        mode_ff;
   logic [31:0] elapsed_ff;
   logic [7:0]  pixel_ff;

   logic [7:0]  prev_mem [mppb_pkg::PIXEL_COUNT];
   logic [23:0] grid_mem [mppb_pkg::PIXEL_COUNT];
   logic [7:0]  prev_rd_ff;
   logic [23:0] grid_rd_ff;

   logic [PW-1:0] clr_ff;
   logic          clear_done_ff;
   logic [PW-1:0] pos_ff;

   logic [2:0]  from_ff, to_ff;
   logic [31:0] base_ff, phase_ff;
   logic [23:0] blend_ff;

   logic [21:0] per;
   assign per = (period_ff == 22'd0) ? 22'd1 : period_ff;

   // restoring divider: (phase << 16) / per, 48 quotient bits
   logic [47:0] quo_ff;
   logic [22:0] rem_ff;
   logic [5:0]  dcnt_ff;
   logic        dbusy_ff;
   logic [22:0] rem_sh;
   logic [23:0] rem_sub;
   assign rem_sh  = {rem_ff[21:0], quo_ff[47]};
   assign rem_sub = {1'b0, rem_sh} - {2'b0, per};

   logic [16:0] frac;
   assign frac = (quo_ff > 48'd65536) ? 17'd65536 : quo_ff[16:0];

   function automatic logic [23:0] pal_get(input logic [2:0] idx,
                                           input logic [23:0] p0, input logic [23:0] p1,
                                           input logic [23:0] p2, input logic [23:0] p3,
                                           input logic [23:0] p4);
      logic [23:0] r;
      r = p0;
      if ({29'd0, idx} < mppb_pkg::PALETTE_SIZE) begin
         case (idx)
            3'd1: r = p1;
            3'd2: r = p2;
            3'd3: r = p3;
            3'd4: r = p4;
            default: r = p0;
         endcase
      end
      return r;
   endfunction

   // one channel per cycle through a shared multiplier pair
   logic [1:0]  ch_ff;
   logic [23:0] ca, cb;
   logic [7:0]  a8, b8;
   logic [25:0] mix_v;
   assign ca = pal_get(from_ff, pal_ff[0], pal_ff[1], pal_ff[2], pal_ff[3], pal_ff[4]);
   assign cb = pal_get(to_ff, pal_ff[0], pal_ff[1], pal_ff[2], pal_ff[3], pal_ff[4]);
   always_comb begin
      case (ch_ff)
         2'd0:    begin a8 = ca[23:16]; b8 = cb[23:16]; end
         2'd1:    begin a8 = ca[15:8];  b8 = cb[15:8];  end
         default: begin a8 = ca[7:0];   b8 = cb[7:0];   end
      endcase
      mix_v = ({9'd0, a8} * (17'd65536 - frac)) + ({9'd0, b8} * frac);
   end

   logic [32:0] nb;
   logic [2:0]  to_inc;
   assign nb     = {1'b0, base_ff} + {11'd0, per};
   assign to_inc = to_ff + 3'd1;
   logic [31:0] base_new;
   assign base_new = (phase_ff >= {10'd0, per}) ?
                     (nb[32] ? 32'hFFFF_FFFF : nb[31:0]) : base_ff;

   logic [7:0]  diff;
   assign diff = (pixel_ff > prev_rd_ff) ? pixel_ff - prev_rd_ff : prev_rd_ff - pixel_ff;
   logic [23:0] grid_new;
   assign grid_new = (diff > threshold_ff) ? blend_ff : grid_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= mppb_pkg::PERIOD_RESET;
         threshold_ff  <= mppb_pkg::THRESHOLD_RESET;
         pal_ff[0]     <= mppb_pkg::PAL0_RESET;
         pal_ff[1]     <= mppb_pkg::PAL1_RESET;
         pal_ff[2]     <= mppb_pkg::PAL2_RESET;
         pal_ff[3]     <= mppb_pkg::PAL3_RESET;
         pal_ff[4]     <= mppb_pkg::PAL4_RESET;
         clr_ff        <= '0;
         clear_done_ff <= 1'b0;
         pos_ff        <= '0;
         from_ff       <= 3'd0;
         to_ff         <= 3'd1;
         base_ff       <= '0;
         phase_ff      <= '0;
         blend_ff      <= mppb_pkg::PAL0_RESET;
         dbusy_ff      <= 1'b0;
         ch_ff         <= 2'd0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               mppb_pkg::REG_PERIOD:    period_ff    <= csr_data[21:0];
               mppb_pkg::REG_THRESHOLD: threshold_ff <= csr_data[7:0];
               mppb_pkg::REG_PAL0:      pal_ff[0]    <= csr_data;
               mppb_pkg::REG_PAL1:      pal_ff[1]    <= csr_data;
               mppb_pkg::REG_PAL2:      pal_ff[2]    <= csr_data;
               mppb_pkg::REG_PAL3:      pal_ff[3]    <= csr_data;
               mppb_pkg::REG_PAL4:      pal_ff[4]    <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
            if ({{(32-PW){1'b0}}, clr_ff} == mppb_pkg::PIXEL_COUNT - 1)
               clear_done_ff <= 1'b1;
         end
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
            dcnt_ff  <= 6'd0;
            quo_ff   <= {phase_ff, 16'd0};
            rem_ff   <= '0;
         end else if (dbusy_ff) begin
            if (rem_sub[23]) begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[46:0], 1'b0};
            end else begin
               rem_ff <= rem_sub[22:0];
               quo_ff <= {quo_ff[46:0], 1'b1};
            end
            dcnt_ff <= dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd47)
               dbusy_ff <= 1'b0;
         end
         if (cmd.div_start)
            ch_ff <= 2'd0;
         else if (cmd.mix_step) begin
            ch_ff <= ch_ff + 2'd1;
            case (ch_ff)
               2'd0:    blend_ff[23:16] <= mix_v[23:16];
               2'd1:    blend_ff[15:8]  <= mix_v[23:16];
               default: blend_ff[7:0]   <= mix_v[23:16];
            endcase
         end
         if (cmd.frame_update) begin
            if (phase_ff >= {10'd0, per}) begin
               from_ff <= to_ff;
               to_ff   <= ({29'd0, to_inc} > mppb_pkg::PALETTE_SIZE - 1) ? 3'd0 : to_inc;
            end
            base_ff  <= base_new;
            phase_ff <= (elapsed_ff >= base_new) ? elapsed_ff - base_new : 32'd0;
            pos_ff   <= '0;
         end
         if (cmd.pix_write) begin
            if ({{(32-PW){1'b0}}, pos_ff} >= mppb_pkg::PIXEL_COUNT - 1)
               pos_ff <= '0;
            else
               pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= in_mode;
         elapsed_ff <= in_elapsed;
         pixel_ff   <= in_pixel;
      end
      prev_rd_ff <= prev_mem[pos_ff];
      grid_rd_ff <= grid_mem[pos_ff];
      if (cmd.clear_step) begin
         prev_mem[clr_ff] <= 8'd0;
         grid_mem[clr_ff] <= mppb_pkg::PAL0_RESET;
      end else if (cmd.pix_write) begin
         prev_mem[pos_ff] <= pixel_ff;
         grid_mem[pos_ff] <= grid_new;
      end
      if (cmd.out_load) begin
         if (mode_ff == mppb_pkg::MODE_FRAME) begin
            out_color     <= blend_ff;
            out_frame_end <= 1'b0;
         end else begin
            out_color     <= grid_new;
            out_frame_end <= ({{(32-PW){1'b0}}, pos_ff} >= mppb_pkg::PIXEL_COUNT - 1);
         end
      end
   end

   assign status.clear_done = clear_done_ff;
   assign status.div_done   = ~dbusy_ff;
   assign status.mode       = mode_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      {{(32-PW){1'b0}}, pos_ff} < mppb_pkg::PIXEL_COUNT)
      else $error("pixel position out of range");
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && cmd.pix_write))
      else $error("pixel write during clear");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> dbusy_ff)
      else $error("divider did not start");

endmodule

// ----- hdl/mppb_control.sv -----
module mppb_control (
   input  logic                 clock,
   input  logic                 reset,
   input  mppb_pkg::status_type status,
   output mppb_pkg::cmd_type    cmd,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready
);

   mppb_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          mix_cnt_ff;
   // divide is started on the first DIVIDE cycle, tracked via a flag
   logic                div_started_ff;
   // frame result loads in OUT once blend is complete and the output register is free
   logic                load_frame;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mppb_pkg::ST_CLEAR:     if (status.clear_done) state_in = mppb_pkg::ST_IDLE;
         mppb_pkg::ST_IDLE:
            if (in_valid && (!out_valid_ff || out_ready)) state_in = mppb_pkg::ST_DIVIDE;
         mppb_pkg::ST_DIVIDE:
            if (status.mode == mppb_pkg::MODE_PIXEL) state_in = mppb_pkg::ST_PIX_READ;
            else if (status.div_done && div_started_ff) state_in = mppb_pkg::ST_MIX;
         mppb_pkg::ST_MIX:       if (mix_cnt_ff == 2'd2) state_in = mppb_pkg::ST_OUT;
         mppb_pkg::ST_PIX_READ:  state_in = mppb_pkg::ST_PIX_WRITE;
         mppb_pkg::ST_PIX_WRITE: state_in = mppb_pkg::ST_OUT;
         mppb_pkg::ST_OUT:       if (!out_valid_ff || out_ready) state_in = mppb_pkg::ST_IDLE;
         default:                state_in = mppb_pkg::ST_IDLE;
      endcase
   end

   assign load_frame = (state_ff == mppb_pkg::ST_OUT) && (status.mode == mppb_pkg::MODE_FRAME);

   always_comb begin
      cmd          = '0;
      in_ready     = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         mppb_pkg::ST_CLEAR:  cmd.clear_step = !status.clear_done;
         mppb_pkg::ST_IDLE: begin
            in_ready    = !out_valid_ff || out_ready;
            cmd.capture = in_valid && (!out_valid_ff || out_ready);
         end
         mppb_pkg::ST_DIVIDE:
            cmd.div_start = (status.mode == mppb_pkg::MODE_FRAME) && !div_started_ff;
         mppb_pkg::ST_MIX:    cmd.mix_step = 1'b1;
         mppb_pkg::ST_PIX_READ: ;
         mppb_pkg::ST_PIX_WRITE: begin
            cmd.pix_write = 1'b1;
            cmd.out_load  = 1'b1;
         end
         mppb_pkg::ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               cmd.out_load = load_frame;
               if (status.mode == mppb_pkg::MODE_FRAME) begin
                  cmd.frame_update = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mppb_pkg::ST_CLEAR;
         out_valid_ff   <= 1'b0;
         mix_cnt_ff     <= 2'd0;
         div_started_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == mppb_pkg::ST_MIX) mix_cnt_ff <= mix_cnt_ff + 2'd1;
         else mix_cnt_ff <= 2'd0;
         if (cmd.div_start) div_started_ff <= 1'b1;
         else if (state_ff != mppb_pkg::ST_DIVIDE) div_started_ff <= 1'b0;
      end
   end

   assign out_valid = out_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> state_ff == mppb_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid)
      else $error("result dropped");
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_update |=> state_ff == mppb_pkg::ST_IDLE)
      else $error("frame update not followed by idle");

endmodule

// ----- hdl/motion_paint_palette_blend.sv -----
// motion_paint_palette_blend
// Input items on req_*: tdata = {pixel_value, elapsed_ms}, tuser = mode
// (0 frame start, 1 pixel). Each item yields one result on rsp_*:
// tdata = {blue, green, red}... packed red lowest, tlast = frame_end.
// A frame start divides phase time by the period in a 48-step restoring
// divider, then mixes three channels on one shared multiplier pair.
// A pixel item reads the previous frame and paint grid memories and
// writes both back.
// One item is in flight at a time; results are held in an output register
// and the next item is accepted only once the result is taken (in the same
// cycle at the earliest); a stalled receiver stalls the input.
// After reset a clearing pass over every pixel location zeroes the previous
// frame memory and fills the grid with the reset value of palette entry
// zero; no item is accepted meanwhile, configuration writes are taken at
// any time.
// csr_*: index selects period, threshold, palette entries zero to four.
module motion_paint_palette_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // elapsed_ms[31:0], pixel_value[39:32]
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   mppb_pkg::cmd_type    cmd;
   mppb_pkg::status_type status;
   logic [23:0]          color;

   assign csr_ready = 1'b1;

   mppb_control u_ctl (
      .clock, .reset, .status, .cmd,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready)
   );

   mppb_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .csr_valid, .csr_index, .csr_data,
      .in_mode(req_tuser), .in_elapsed(req_tdata[31:0]), .in_pixel(req_tdata[39:32]),
      .out_color(color), .out_frame_end(rsp_tlast)
   );

   assign rsp_tdata = {color[7:0], color[15:8], color[23:16]};

endmodule

// ----- tb/sv/tb_motion_paint_palette_blend.sv -----
module tb_motion_paint_palette_blend;
   timeunit 1ns;
   timeprecision 1ps;

   class blend_scoreboard;
      logic [21:0] period;
      logic [7:0]  thresh;
      logic [23:0] pal [mppb_pkg::PAL_REGS];
      logic [7:0]  prev_pix [mppb_pkg::PIXEL_COUNT];
      logic [23:0] grid [mppb_pkg::PIXEL_COUNT];
      int unsigned pos;
      logic [2:0]  from_idx;
      logic [2:0]  to_idx;
      logic [31:0] base;
      logic [31:0] phase;
      logic [23:0] blend;
      logic [24:0] pending [$];
      int          mismatches;

      function new();
         period = mppb_pkg::PERIOD_RESET;
         thresh = mppb_pkg::THRESHOLD_RESET;
         pal[0] = mppb_pkg::PAL0_RESET; pal[1] = mppb_pkg::PAL1_RESET;
         pal[2] = mppb_pkg::PAL2_RESET;
         pal[3] = mppb_pkg::PAL3_RESET; pal[4] = mppb_pkg::PAL4_RESET;
         foreach (prev_pix[i]) begin
            prev_pix[i] = 0;
            grid[i] = mppb_pkg::PAL0_RESET;
         end
         pos = 0; from_idx = 0; to_idx = 1; base = 0; phase = 0;
         blend = mppb_pkg::PAL0_RESET; mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         if (idx == mppb_pkg::REG_PERIOD) period = val[21:0];
         else if (idx == mppb_pkg::REG_THRESHOLD) thresh = val[7:0];
         else if (idx >= mppb_pkg::REG_PAL0 && idx <= mppb_pkg::REG_PAL4)
            pal[idx - mppb_pkg::REG_PAL0] = val;
      endfunction

      function logic [23:0] entry(logic [2:0] idx);
         if (idx < mppb_pkg::PALETTE_SIZE) return pal[idx];
         return pal[0];
      endfunction

      function logic [7:0] mix(logic [7:0] a, logic [7:0] b, logic [16:0] f);
         logic [40:0] v;
         v = 41'(a) * (41'd65536 - 41'(f)) + 41'(b) * 41'(f);
         return v[23:16];
      endfunction

      function void note_item(logic mode, logic [31:0] elapsed, logic [7:0] px);
         logic [23:0] color, a, b;
         logic        fend;
         logic [31:0] per;
         logic [63:0] frac, nb;
         logic [7:0]  old, diff;
         fend = 0;
         if (mode == mppb_pkg::MODE_FRAME) begin
            per = (period == 0) ? 32'd1 : 32'(period);
            frac = {16'd0, phase, 16'd0} / 64'(per);
            if (frac > 65536) frac = 65536;
            a = entry(from_idx); b = entry(to_idx);
            blend = {mix(a[23:16], b[23:16], frac[16:0]),
                     mix(a[15:8], b[15:8], frac[16:0]), mix(a[7:0], b[7:0], frac[16:0])};
            if (phase >= per) begin
               nb = 64'(base) + 64'(per);
               base = (nb > 64'hFFFFFFFF) ? 32'hFFFFFFFF : nb[31:0];
               from_idx = to_idx;
               to_idx = to_idx + 3'd1;
               if (to_idx > mppb_pkg::PALETTE_SIZE - 1) to_idx = 0;
            end
            phase = (elapsed >= base) ? elapsed - base : 32'd0;
            pos = 0;
            color = blend;
         end else begin
            if (pos >= mppb_pkg::PIXEL_COUNT) pos = 0;
            old = prev_pix[pos];
            diff = (px > old) ? px - old : old - px;
            if (diff > thresh) grid[pos] = blend;
            prev_pix[pos] = px;
            color = grid[pos];
            if (pos + 1 >= mppb_pkg::PIXEL_COUNT) begin
               fend = 1; pos = 0;
            end else pos = pos + 1;
         end
         pending.push_back({fend, color});
      endfunction

      function void check_result(logic [23:0] data, logic last);
         logic [24:0] e;
         logic [23:0] got;
         got = {data[7:0], data[15:8], data[23:16]};
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h last %b", got, last);
            return;
         end
         e = pending.pop_front();
         if (e[23:0] !== got || e[24] !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected rgb %h last %b, got rgb %h last %b",
                        e[23:0], e[24], got, last);
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [39:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [23:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   blend_scoreboard sb;
   bit    calm;
   int    idle_cycles;
   int    stall_left;

   motion_paint_palette_blend dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic send_item(logic mode, logic [31:0] elapsed, logic [7:0] px);
      int gap;
      csr_valid <= 0;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= mode; req_tdata <= {px, elapsed};
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, elapsed, px);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      req_tvalid <= 0;
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      csr_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic frame_burst(int npix, logic [31:0] t);
      send_item(mppb_pkg::MODE_FRAME, t, 0);
      for (int i = 0; i < npix; i++)
         send_item(mppb_pkg::MODE_PIXEL, $urandom, 8'($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         stall_left <= $urandom_range(0, 8);
      end else rsp_tready <= 1;
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 60000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [31:0] t;
      sb = new();
      calm = 0;
      reset <= 1; req_tvalid <= 0; req_tuser <= 0; req_tdata <= 0;
      csr_valid <= 0; csr_index <= 0; csr_data <= 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      // pixels before any frame start, then period edge cases
      send_item(mppb_pkg::MODE_PIXEL, 0, 8'hFF);
      send_item(mppb_pkg::MODE_PIXEL, 0, 8'h00);
      send_item(mppb_pkg::MODE_PIXEL, 0, 8'h01);
      send_item(mppb_pkg::MODE_FRAME, 32'hFFFFFFFF, 8'hFF);
      send_item(mppb_pkg::MODE_FRAME, 0, 0);
      send_item(mppb_pkg::MODE_FRAME, 32'd30000, 0);
      send_item(mppb_pkg::MODE_FRAME, 32'd10, 0);
      drain();
      write_csr(mppb_pkg::REG_PERIOD, 0);
      write_csr(mppb_pkg::REG_THRESHOLD, 0);
      write_csr(mppb_pkg::REG_PAL0, 24'h000000);
      write_csr(mppb_pkg::REG_PAL1, 24'hFFFFFF);
      write_csr(mppb_pkg::REG_PAL2, 24'hFF00FF);
      write_csr(mppb_pkg::REG_PAL3, 24'h00FF00);
      write_csr(mppb_pkg::REG_PAL4, 24'h123456);
      for (int i = 0; i < 8; i++) send_item(mppb_pkg::MODE_FRAME, i * 3, 0);
      send_item(mppb_pkg::MODE_PIXEL, 0, 8'hFF);
      send_item(mppb_pkg::MODE_PIXEL, 0, 8'h00);
      drain();
      write_csr(mppb_pkg::REG_PERIOD, 24'h3FFFFF);
      write_csr(mppb_pkg::REG_THRESHOLD, 255);
      send_item(mppb_pkg::MODE_FRAME, 32'hFFFFFFFF, 0);
      send_item(mppb_pkg::MODE_FRAME, 32'h003FFFFF, 0);
      send_item(mppb_pkg::MODE_FRAME, 32'hFFFFFFFF, 0);
      send_item(mppb_pkg::MODE_PIXEL, 0, 8'hFF);
      drain();
      // short pixel run at threshold zero
      write_csr(mppb_pkg::REG_PERIOD, 7);
      write_csr(mppb_pkg::REG_THRESHOLD, 0);
      send_item(mppb_pkg::MODE_FRAME, 5, 0);
      for (int i = 0; i < 16; i++)
         send_item(mppb_pkg::MODE_PIXEL, 0, 8'($urandom_range(0, 255)));
      drain();
      t = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(mppb_pkg::REG_PERIOD,
                   (ph % 2) ? 24'($urandom_range(1, 200)) : 24'($urandom_range(1, 24'h3FFFFF)));
         write_csr(mppb_pkg::REG_THRESHOLD, (ph == 5) ? 24'd0 : 24'($urandom_range(0, 255)));
         write_csr(3'(mppb_pkg::REG_PAL0 + $urandom_range(0, 4)), 24'($urandom));
         if (ph == 5) calm = 1;
         for (int k = 0; k < 20; k++) begin
            t = t + $urandom_range(0, 150);
            if ($urandom_range(0, 9) == 0) t = $urandom;
            frame_burst($urandom_range(0, 20), t);
         end
         drain();
      end
      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/mppb_pkg.sv
hdl/mppb_datapath.sv
hdl/mppb_control.sv
hdl/motion_paint_palette_blend.sv
tb/sv/tb_motion_paint_palette_blend.sv
